[rtl/fixed_wing_autopilot_step_defines.svh]
// Assertion macros for the autopilot step block.
`ifndef FIXED_WING_AUTOPILOT_STEP_DEFINES_SVH
`define FIXED_WING_AUTOPILOT_STEP_DEFINES_SVH
`ifndef SYNTH
// Check a condition in the same cycle as its trigger.
`define FWAP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: label");
// Check a condition in the cycle after its trigger.
`define FWAP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define FWAP_ASSERT_NOW(label, ante, cons)
`define FWAP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/fwap_pkg.sv]
`default_nettype none
package fwap_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int WIDE_WIDTH = DATA_WIDTH + 8;
   localparam int GAIN_WIDTH = 17;
   localparam int PROD_WIDTH = GAIN_WIDTH + DATA_WIDTH + 1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [DATA_WIDTH:0]   sum_type;
   typedef logic signed [WIDE_WIDTH-1:0] wide_type;
   typedef logic signed [GAIN_WIDTH-1:0] gain_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam sum_type  SUM_MIN  = {1'b1, {DATA_WIDTH{1'b0}}};

   // Fixed limits and setpoints, Q16.16
   localparam data_type LIM_30DEG   = data_type'(34315);
   localparam data_type LIM_20DEG   = data_type'(22877);
   localparam data_type THETA_TO    = data_type'(17157);
   localparam data_type THR_MAX     = data_type'(131072);
   localparam data_type THR_LIM     = data_type'(163840);
   localparam data_type THR_DESC    = data_type'(16384);
   localparam data_type ALT_TAKEOFF = data_type'(983040);
   localparam data_type H_HOLD      = data_type'(1310720);

   // Flight modes
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_TAKEOFF = 2'd0;
   localparam mode_type MODE_CLIMB   = 2'd1;
   localparam mode_type MODE_HOLD    = 2'd2;
   localparam mode_type MODE_DESCEND = 2'd3;

   // PI loop slots
   typedef logic [2:0] loop_type;
   localparam loop_type LOOP_COURSE   = 3'd0;
   localparam loop_type LOOP_CLIMB    = 3'd1;
   localparam loop_type LOOP_HOLD_THR = 3'd2;
   localparam loop_type LOOP_HOLD_ALT = 3'd3;
   localparam loop_type LOOP_DESCEND  = 3'd4;
   localparam int LOOP_COUNT = 5;

   // Register map, one 64-bit slot each
   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_COURSE_ROLL = 3'd0;
   localparam reg_index_type REG_PITCH_ALT   = 3'd1;
   localparam reg_index_type REG_AIRSPEED    = 3'd2;
   localparam reg_index_type REG_FILTER      = 3'd3;
   localparam reg_index_type REG_TRIM        = 3'd4;

   // Saturate a wide value to the data width.
   function automatic data_type sat_dw(input wide_type x);
      if (x > wide_type'(DATA_MAX)) begin
         return DATA_MAX;
      end else if (x < wide_type'(DATA_MIN)) begin
         return DATA_MIN;
      end else begin
         return data_type'(x[DATA_WIDTH-1:0]);
      end
   endfunction

   // Clamp a wide value to +-lim.
   function automatic data_type clamp_lim(input wide_type x, input data_type lim);
      wide_type lw;
      lw = wide_type'(lim);
      if (x > lw) begin
         return lim;
      end else if (x < -lw) begin
         return -lim;
      end else begin
         return data_type'(x[DATA_WIDTH-1:0]);
      end
   endfunction

   // Pick one signed 16-bit gain field out of a packed register.
   function automatic gain_type gain_field(input logic [63:0] r, input logic [1:0] k);
      logic signed [15:0] f;
      f = r[16*k +: 16];
      return gain_type'(f);
   endfunction

endpackage
`default_nettype wire

[rtl/fixed_wing_autopilot_step.sv]
// Channel  Handshake               Contents
// req      req_valid / req_stall   one control sample (measurements, commands, first flag)
// rsp      rsp_valid / rsp_stall   surface, throttle, attitude commands and flight mode
// csr      psel/penable/pwrite     gains, filter constants, trim throttle (64-bit slots)
//
// A sample is taken in an idle cycle and then keeps the block busy until its output load:
// each PI loop is 8 steps, the yaw damper 8, each PD loop 4, the hold throttle 1 and the
// output load 1, all on one shared 17x33 multiplier with rounding. A first sample in
// takeoff mode is shortest; a later sample in hold mode (three PI loops) is longest.
// A finished result waits in the output register, so a new sample is taken while
// rsp_stall is high; the load waits only while that register is still full.
// Reset is synchronous and clears the configuration and control registers, integrators and washout state.
`default_nettype none
`include "fixed_wing_autopilot_step_defines.svh"
module fixed_wing_autopilot_step import fwap_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_first_step,
   input  wire data_type    req_altitude,
   input  wire data_type    req_airspeed,
   input  wire data_type    req_roll_angle,
   input  wire data_type    req_pitch_angle,
   input  wire data_type    req_course_angle,
   input  wire data_type    req_roll_rate,
   input  wire data_type    req_pitch_rate,
   input  wire data_type    req_yaw_rate,
   input  wire data_type    req_cmd_airspeed,
   input  wire data_type    req_cmd_altitude,
   input  wire data_type    req_cmd_course,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output data_type         rsp_elevator,
   output data_type         rsp_aileron,
   output data_type         rsp_rudder,
   output data_type         rsp_throttle,
   output data_type         rsp_roll_command,
   output data_type         rsp_pitch_command,
   output mode_type         rsp_flight_mode,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [5:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PI   = 6'b000010,
      ST_YAW  = 6'b000100,
      ST_PD   = 6'b001000,
      ST_THR  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   // Configuration registers
   logic [63:0] course_roll_ff, pitch_alt_ff, airspeed_gains_ff, filter_ff;
   data_type    trim_ff;
   logic        csr_write;
   reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         course_roll_ff    <= '0;
         pitch_alt_ff      <= '0;
         airspeed_gains_ff <= '0;
         filter_ff         <= '0;
         trim_ff           <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COURSE_ROLL: course_roll_ff    <= pwdata;
            REG_PITCH_ALT:   pitch_alt_ff      <= pwdata;
            REG_AIRSPEED:    airspeed_gains_ff <= pwdata;
            REG_FILTER:      filter_ff         <= pwdata;
            REG_TRIM:        trim_ff           <= data_type'(pwdata[DATA_WIDTH-1:0]);
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_index)
         REG_COURSE_ROLL: prdata = course_roll_ff;
         REG_PITCH_ALT:   prdata = pitch_alt_ff;
         REG_AIRSPEED:    prdata = airspeed_gains_ff;
         REG_FILTER:      prdata = filter_ff;
         REG_TRIM:        prdata = {{(64-DATA_WIDTH){1'b0}}, trim_ff};
         default:         prdata = '0;
      endcase
   end

   // Control registers
   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   loop_type  loop_id_ff, loop_id_in;
   logic      pd_elev_ff, pd_elev_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Loop state
   data_type integ_ff [LOOP_COUNT];
   data_type integ_in [LOOP_COUNT];
   data_type last_ff  [LOOP_COUNT];
   data_type last_in  [LOOP_COUNT];
   data_type xi_ff, xi_in;

   // Captured sample
   data_type h_ff, h_in, va_ff, va_in, phi_ff, phi_in, theta_ff, theta_in;
   data_type chi_ff, chi_in, p_ff, p_in, q_ff, q_in, r_ff, r_in;
   data_type vac_ff, vac_in, hc_ff, hc_in, chic_ff, chic_in;

   // Scratch
   data_type e_ff, e_in, t1_ff, t1_in, integ_w_ff, integ_w_in, u_ff, u_in, v_ff, v_in;
   sum_type  s_ff, s_in;
   wide_type kpe_ff, kpe_in, a_ff, a_in, krr_ff, krr_in;

   // Results
   data_type phic_ff, phic_in, thetac_ff, thetac_in, da_ff, da_in, dr_ff, dr_in;
   data_type dt_ff, dt_in, de_ff, de_in;
   mode_type mode_ff, mode_in;

   // Output register
   data_type rsp_elevator_ff, rsp_elevator_in, rsp_aileron_ff, rsp_aileron_in;
   data_type rsp_rudder_ff, rsp_rudder_in, rsp_throttle_ff, rsp_throttle_in;
   data_type rsp_roll_command_ff, rsp_roll_command_in;
   data_type rsp_pitch_command_ff, rsp_pitch_command_in;
   mode_type rsp_flight_mode_ff, rsp_flight_mode_in;

   // Shared multiplier
   logic     mul_en;
   gain_type mul_gain;
   sum_type  mul_data;
   wide_type rnd12, rnd13;

   fwap_mul u_mul (
      .clock     (clock),
      .mul_en    (mul_en),
      .mul_gain  (mul_gain),
      .mul_data  (mul_data),
      .rnd12_out (rnd12),
      .rnd13_out (rnd13)
   );

   // Gains
   gain_type ts, kr, npwo;
   assign ts   = gain_field(filter_ff, 2'd0);
   assign kr   = gain_field(filter_ff, 2'd2);
   assign npwo = gain_type'(-gain_field(filter_ff, 2'd3));

   // Select the active PI loop
   data_type pi_yc, pi_y, pi_lim;
   gain_type pi_kp, pi_ki;
   always_comb begin
      case (loop_id_ff) inside
         LOOP_COURSE: begin
            pi_yc = chic_ff; pi_y = chi_ff; pi_lim = LIM_30DEG;
            pi_kp = gain_field(course_roll_ff, 2'd0);
            pi_ki = gain_field(course_roll_ff, 2'd1);
         end
         LOOP_HOLD_THR: begin
            pi_yc = vac_ff; pi_y = va_ff; pi_lim = THR_LIM;
            pi_kp = gain_field(airspeed_gains_ff, 2'd0);
            pi_ki = gain_field(airspeed_gains_ff, 2'd1);
         end
         LOOP_HOLD_ALT: begin
            pi_yc = hc_ff; pi_y = h_ff; pi_lim = LIM_30DEG;
            pi_kp = gain_field(pitch_alt_ff, 2'd2);
            pi_ki = gain_field(pitch_alt_ff, 2'd3);
         end
         default: begin
            pi_yc = vac_ff; pi_y = va_ff; pi_lim = LIM_30DEG;
            pi_kp = gain_field(airspeed_gains_ff, 2'd2);
            pi_ki = gain_field(airspeed_gains_ff, 2'd3);
         end
      endcase
   end

   // Select the active PD loop
   data_type pd_yc, pd_y, pd_ydot;
   gain_type pd_kp, pd_kd;
   always_comb begin
      if (pd_elev_ff) begin
         pd_yc = thetac_ff; pd_y = theta_ff; pd_ydot = q_ff;
         pd_kp = gain_field(pitch_alt_ff, 2'd0);
         pd_kd = gain_field(pitch_alt_ff, 2'd1);
      end else begin
         pd_yc = phic_ff; pd_y = phi_ff; pd_ydot = p_ff;
         pd_kp = gain_field(course_roll_ff, 2'd2);
         pd_kd = gain_field(course_roll_ff, 2'd3);
      end
   end

   // Mode thresholds
   logic below_takeoff, below_climb, below_hold;
   assign below_takeoff = h_ff < ALT_TAKEOFF;
   assign below_climb   = wide_type'(h_ff) < wide_type'(hc_ff) - wide_type'(H_HOLD);
   assign below_hold    = wide_type'(h_ff) < wide_type'(hc_ff) + wide_type'(H_HOLD);

   sum_type  s_raw;
   wide_type thr_sum;
   assign s_raw   = sum_type'(e_ff) + sum_type'(last_ff[loop_id_ff]);
   assign thr_sum = wide_type'(trim_ff) + wide_type'(u_ff);

   // Sequencer
   always_comb begin
      state_in = state_ff; step_in = step_ff; loop_id_in = loop_id_ff;
      pd_elev_in = pd_elev_ff;
      integ_in = integ_ff; last_in = last_ff; xi_in = xi_ff;
      h_in = h_ff; va_in = va_ff; phi_in = phi_ff; theta_in = theta_ff;
      chi_in = chi_ff; p_in = p_ff; q_in = q_ff; r_in = r_ff;
      vac_in = vac_ff; hc_in = hc_ff; chic_in = chic_ff;
      e_in = e_ff; t1_in = t1_ff; integ_w_in = integ_w_ff; u_in = u_ff; v_in = v_ff;
      s_in = s_ff; kpe_in = kpe_ff; a_in = a_ff; krr_in = krr_ff;
      phic_in = phic_ff; thetac_in = thetac_ff; da_in = da_ff; dr_in = dr_ff;
      dt_in = dt_ff; de_in = de_ff; mode_in = mode_ff;
      rsp_elevator_in = rsp_elevator_ff; rsp_aileron_in = rsp_aileron_ff;
      rsp_rudder_in = rsp_rudder_ff; rsp_throttle_in = rsp_throttle_ff;
      rsp_roll_command_in = rsp_roll_command_ff;
      rsp_pitch_command_in = rsp_pitch_command_ff;
      rsp_flight_mode_in = rsp_flight_mode_ff;
      mul_en = 1'b0; mul_gain = '0; mul_data = '0;

      // Drop the output word once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               h_in = req_altitude; va_in = req_airspeed;
               phi_in = req_roll_angle; theta_in = req_pitch_angle;
               chi_in = req_course_angle; p_in = req_roll_rate;
               q_in = req_pitch_rate; r_in = req_yaw_rate;
               vac_in = req_cmd_airspeed; hc_in = req_cmd_altitude;
               chic_in = req_cmd_course;
               step_in = '0;
               if (req_first_step) begin
                  for (int i = 0; i < LOOP_COUNT; i++) begin
                     integ_in[i] = '0;
                     last_in[i]  = '0;
                  end
                  xi_in = '0; phic_in = '0; dr_in = '0;
                  pd_elev_in = 1'b0;
                  state_in = ST_PD;
               end else begin
                  loop_id_in = LOOP_COURSE;
                  state_in = ST_PI;
               end
            end
         end
         ST_PI: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: e_in = sat_dw(wide_type'(pi_yc) - wide_type'(pi_y));
               3'd1: begin
                  s_in = (s_raw == SUM_MIN) ? SUM_MIN + sum_type'(1) : s_raw;
                  mul_en = 1'b1; mul_gain = pi_kp; mul_data = sum_type'(e_ff);
               end
               3'd2: begin
                  kpe_in = rnd12;
                  mul_en = 1'b1; mul_gain = pi_ki; mul_data = s_ff;
               end
               3'd3: t1_in = sat_dw(rnd12);
               3'd4: begin
                  mul_en = 1'b1; mul_gain = ts; mul_data = sum_type'(t1_ff);
               end
               3'd5: integ_w_in = sat_dw(wide_type'(integ_ff[loop_id_ff]) + rnd13);
               3'd6: u_in = clamp_lim(kpe_ff + wide_type'(integ_w_ff), pi_lim);
               default: begin
                  // Write back with anti-windup and route the output
                  integ_in[loop_id_ff] = (pi_ki != '0) ?
                     sat_dw(wide_type'(u_ff) - kpe_ff) : integ_w_ff;
                  last_in[loop_id_ff] = e_ff;
                  step_in = '0;
                  case (loop_id_ff)
                     LOOP_COURSE: begin
                        phic_in = u_ff;
                        state_in = ST_YAW;
                     end
                     LOOP_HOLD_THR: state_in = ST_THR;
                     default: begin
                        thetac_in = u_ff;
                        pd_elev_in = 1'b1;
                        state_in = ST_PD;
                     end
                  endcase
               end
            endcase
         end
         ST_YAW: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  mul_en = 1'b1; mul_gain = npwo; mul_data = sum_type'(xi_ff);
               end
               3'd1: begin
                  a_in = rnd12;
                  mul_en = 1'b1; mul_gain = kr; mul_data = sum_type'(r_ff);
               end
               3'd2: krr_in = rnd12;
               3'd3: v_in = sat_dw(a_ff + krr_ff);
               3'd4: begin
                  mul_en = 1'b1; mul_gain = ts; mul_data = sum_type'(v_ff);
               end
               3'd5: xi_in = sat_dw(wide_type'(xi_ff) + rnd12);
               3'd6: begin
                  mul_en = 1'b1; mul_gain = npwo; mul_data = sum_type'(xi_ff);
               end
               default: begin
                  dr_in = clamp_lim(rnd12 + krr_ff, LIM_20DEG);
                  pd_elev_in = 1'b0;
                  step_in = '0;
                  state_in = ST_PD;
               end
            endcase
         end
         ST_PD: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: e_in = sat_dw(wide_type'(pd_yc) - wide_type'(pd_y));
               3'd1: begin
                  mul_en = 1'b1; mul_gain = pd_kp; mul_data = sum_type'(e_ff);
               end
               3'd2: begin
                  kpe_in = rnd12;
                  mul_en = 1'b1; mul_gain = pd_kd; mul_data = sum_type'(pd_ydot);
               end
               default: begin
                  step_in = '0;
                  if (pd_elev_ff) begin
                     de_in = clamp_lim(kpe_ff - rnd12, LIM_30DEG);
                     state_in = ST_OUT;
                  end else begin
                     da_in = clamp_lim(kpe_ff - rnd12, LIM_30DEG);
                     // Pick the flight mode
                     if (below_takeoff) begin
                        mode_in = MODE_TAKEOFF; dt_in = THR_MAX; thetac_in = THETA_TO;
                        pd_elev_in = 1'b1;
                        state_in = ST_PD;
                     end else if (below_climb) begin
                        mode_in = MODE_CLIMB; dt_in = THR_MAX;
                        loop_id_in = LOOP_CLIMB;
                        state_in = ST_PI;
                     end else if (below_hold) begin
                        mode_in = MODE_HOLD;
                        loop_id_in = LOOP_HOLD_THR;
                        state_in = ST_PI;
                     end else begin
                        mode_in = MODE_DESCEND; dt_in = THR_DESC;
                        loop_id_in = LOOP_DESCEND;
                        state_in = ST_PI;
                     end
                  end
               end
            endcase
         end
         ST_THR: begin
            // Add trim, floor at zero
            dt_in = thr_sum[WIDE_WIDTH-1] ? '0 : sat_dw(thr_sum);
            loop_id_in = LOOP_HOLD_ALT;
            step_in = '0;
            state_in = ST_PI;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_elevator_in = de_ff; rsp_aileron_in = da_ff;
               rsp_rudder_in = dr_ff; rsp_throttle_in = dt_ff;
               rsp_roll_command_in = phic_ff; rsp_pitch_command_in = thetac_ff;
               rsp_flight_mode_in = mode_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         loop_id_ff <= LOOP_COURSE;
         pd_elev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LOOP_COUNT; i++) begin
            integ_ff[i] <= '0;
            last_ff[i]  <= '0;
         end
         xi_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         loop_id_ff <= loop_id_in;
         pd_elev_ff <= pd_elev_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff <= integ_in;
         last_ff <= last_in;
         xi_ff <= xi_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      h_ff <= h_in; va_ff <= va_in; phi_ff <= phi_in; theta_ff <= theta_in;
      chi_ff <= chi_in; p_ff <= p_in; q_ff <= q_in; r_ff <= r_in;
      vac_ff <= vac_in; hc_ff <= hc_in; chic_ff <= chic_in;
      e_ff <= e_in; t1_ff <= t1_in; integ_w_ff <= integ_w_in; u_ff <= u_in; v_ff <= v_in;
      s_ff <= s_in; kpe_ff <= kpe_in; a_ff <= a_in; krr_ff <= krr_in;
      phic_ff <= phic_in; thetac_ff <= thetac_in; da_ff <= da_in; dr_ff <= dr_in;
      dt_ff <= dt_in; de_ff <= de_in; mode_ff <= mode_in;
      rsp_elevator_ff <= rsp_elevator_in; rsp_aileron_ff <= rsp_aileron_in;
      rsp_rudder_ff <= rsp_rudder_in; rsp_throttle_ff <= rsp_throttle_in;
      rsp_roll_command_ff <= rsp_roll_command_in;
      rsp_pitch_command_ff <= rsp_pitch_command_in;
      rsp_flight_mode_ff <= rsp_flight_mode_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elevator      = rsp_elevator_ff;
   assign rsp_aileron       = rsp_aileron_ff;
   assign rsp_rudder        = rsp_rudder_ff;
   assign rsp_throttle      = rsp_throttle_ff;
   assign rsp_roll_command  = rsp_roll_command_ff;
   assign rsp_pitch_command = rsp_pitch_command_ff;
   assign rsp_flight_mode   = rsp_flight_mode_ff;

   `FWAP_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `FWAP_ASSERT_NOW(a_loop_id_range, state_ff == ST_PI, loop_id_ff <= LOOP_DESCEND)
   `FWAP_ASSERT_NOW(a_hold_throttle_nonneg, rsp_valid_ff && rsp_flight_mode_ff == MODE_HOLD, !rsp_throttle_ff[DATA_WIDTH-1])

endmodule
`default_nettype wire

[rtl/fwap_mul.sv]
`default_nettype none
module fwap_mul import fwap_pkg::*; (
   input  wire logic     clock,
   input  wire logic     mul_en,
   input  wire gain_type mul_gain,
   input  wire sum_type  mul_data,
   output wide_type      rnd12_out,
   output wide_type      rnd13_out
);

   localparam prod_type HALF12 = prod_type'(2048);
   localparam prod_type HALF13 = prod_type'(4096);

   prod_type prod_ff;
   prod_type prod_in;
   prod_type r12;
   prod_type r13;

   // Form the exact product
   assign prod_in = prod_type'(mul_gain) * prod_type'(mul_data);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Round half up and drop fraction bits
   always_comb begin
      r12 = (prod_ff + HALF12) >>> 12;
      r13 = (prod_ff + HALF13) >>> 13;
      rnd12_out = wide_type'(r12);
      rnd13_out = wide_type'(r13);
   end

endmodule
`default_nettype wire
